// ===== hdl/rti_pkg.sv =====
package rti_pkg;

    localparam int DIV_W       = 64;
    localparam int QUO_W       = 32;
    localparam int DOT_W       = 66;
    localparam int THRESH_W    = 20;
    localparam int CFG_DATA_W  = 63;
    localparam int OUT_TDATA_W = 72;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd1074;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_U_OUT    = 2'd2,
        ST_V_OUT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_VERTEX0    = 2'd0,
        CFG_EDGE1      = 2'd1,
        CFG_EDGE2      = 2'd2,
        CFG_DET_THRESH = 2'd3
    } cfg_index_t;

    // Result of the dot-product front end, ready for the dividers.
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic             tneg;
        logic [DIV_W-1:0] tmag;
        logic [DIV_W-1:0] dmag;
        logic [DIV_W-1:0] u_num;
        logic [DIV_W-1:0] v_num;
    } front_t;

    // Flags that travel beside the divider pipeline.
    typedef struct packed {
        logic    valid;
        status_t status;
        logic    tneg;
        logic    t_sat;
        logic    u_sat;
        logic    v_sat;
    } side_t;

endpackage

// ===== hdl/ray_triangle_intersection.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata: origin x, y, z, direction x, y, z (signed Q10.10)
// m_axis    out        tdata: status, hit_distance, bary_u, bary_v
// cfg       in         index and data of a triangle or threshold register
//
// One ray is taken every cycle while the output is not stalled; the cross
// and dot products come first, then the pipelined restoring dividers for
// the distance, u and v, which are separate and of equal depth side by side.
// Reset clears all valid bits and loads the configuration registers with their defaults.
// A stall on the output freezes the whole pipeline; nothing is dropped.
module ray_triangle_intersection #(
    parameter int COORD_WIDTH = 21
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // origin x, y, z, direction x, y, z from bit 0 up, zero padded
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [1:0], hit_distance [33:2], bary_u [50:34], bary_v [67:51]
    output logic [rti_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int W     = COORD_WIDTH;
    localparam int STEPS = rti_pkg::QUO_W;

    logic [rti_pkg::CFG_DATA_W-1:0] vertex0_reg, edge1_reg, edge2_reg;
    logic [rti_pkg::THRESH_W-1:0]   thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex0_reg <= '0;
            edge1_reg   <= '0;
            edge2_reg   <= '0;
            thresh_reg  <= rti_pkg::THRESH_RESET;
        end else if (cfg_valid) begin
            unique case (rti_pkg::cfg_index_t'(cfg_index))
                rti_pkg::CFG_VERTEX0:    vertex0_reg <= cfg_data;
                rti_pkg::CFG_EDGE1:      edge1_reg   <= cfg_data;
                rti_pkg::CFG_EDGE2:      edge2_reg   <= cfg_data;
                rti_pkg::CFG_DET_THRESH: thresh_reg  <= cfg_data[rti_pkg::THRESH_W-1:0];
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    logic [rti_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_in
            assign org[k] = $signed(s_tdata[k*W +: W]);
            assign dir[k] = $signed(s_tdata[(k+3)*W +: W]);
        end
    endgenerate

    rti_pkg::front_t fo;

    rti_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .org       (org),
        .dir       (dir),
        .vertex0   (vertex0_reg),
        .edge1     (edge1_reg),
        .edge2     (edge2_reg),
        .det_thresh(thresh_reg),
        .fo        (fo)
    );

    logic [STEPS-1:0] t_quo, u_quo, v_quo;

    // Distance: 16 integer and 16 fraction bits of tmag / dmag.
    rti_div #(.STEPS(STEPS)) u_div_t (
        .aclk   (aclk),
        .en     (en),
        .rem_in ({16'd0, fo.tmag[63:16]}),
        .bits_in({fo.tmag[15:0], 16'd0}),
        .den    (fo.dmag),
        .quo    (t_quo)
    );

    rti_div #(.STEPS(STEPS)) u_div_u (
        .aclk   (aclk),
        .en     (en),
        .rem_in (fo.u_num),
        .bits_in('0),
        .den    (fo.dmag),
        .quo    (u_quo)
    );

    rti_div #(.STEPS(STEPS)) u_div_v (
        .aclk   (aclk),
        .en     (en),
        .rem_in (fo.v_num),
        .bits_in('0),
        .den    (fo.dmag),
        .quo    (v_quo)
    );

    rti_pkg::side_t side_next;
    rti_pkg::side_t side_reg [STEPS];

    always_comb begin
        side_next.valid  = fo.valid;
        side_next.status = fo.status;
        side_next.tneg   = fo.tneg;
        side_next.t_sat  = {16'd0, fo.tmag[63:16]} >= fo.dmag;
        side_next.u_sat  = fo.u_num >= fo.dmag;
        side_next.v_sat  = fo.v_num >= fo.dmag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STEPS; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rti_pkg::side_t last;
    logic [32:0]    mag, lim;
    logic [31:0]    hit_dist;
    logic [16:0]    bu, bv;

    assign last = side_reg[STEPS-1];

    always_comb begin
        lim = last.tneg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        mag = last.t_sat ? lim : {1'b0, t_quo};
        if (mag > lim) begin
            mag = lim;
        end
        hit_dist = last.tneg ? (~mag[31:0] + 32'd1) : mag[31:0];
        bu       = last.u_sat ? 17'h10000 : {1'b0, u_quo[STEPS-1 -: 16]};
        bv       = last.v_sat ? 17'h10000 : {1'b0, v_quo[STEPS-1 -: 16]};
        if (last.status != rti_pkg::ST_HIT) begin
            hit_dist = '0;
            bu       = '0;
            bv       = '0;
        end
        m_tdata_next = {4'd0, bv, bu, hit_dist, last.status};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= last.valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/rti_mul.sv =====
module rti_mul #(
    parameter int AW = 22,
    parameter int BW = 43
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [63:0]   p
);

    // Operand b is split in two halves; the partial products are
    // registered and combined in the second stage. The result wraps to 64 bits.
    localparam int LW = BW / 2;
    localparam int HW = BW - LW;
    localparam int PW = AW + BW;

    logic signed [AW+LW:0]   lo_reg;
    logic signed [AW+HW-1:0] hi_reg;
    logic signed [63:0]      p_reg;
    logic signed [PW-1:0]    full;

    assign full = (PW'(hi_reg) <<< LW) + PW'(lo_reg);
    assign p    = p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= a * $signed({1'b0, b[LW-1:0]});
            hi_reg <= a * $signed(b[BW-1:LW]);
            p_reg  <= 64'(full);
        end
    end

endmodule

// ===== hdl/rti_div.sv =====
module rti_div #(
    parameter int STEPS = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [rti_pkg::DIV_W-1:0] rem_in,
    input  logic [STEPS-1:0]         bits_in,
    input  logic [rti_pkg::DIV_W-1:0] den,
    output logic [STEPS-1:0]         quo
);

    // Restoring division, one quotient bit per stage. The start remainder
    // must be below the divisor; bits_in is shifted in from its top bit.
    localparam int DW = rti_pkg::DIV_W;

    logic [DW-1:0]    rem_reg  [STEPS];
    logic [DW-1:0]    den_reg  [STEPS];
    logic [STEPS-1:0] bits_reg [STEPS];
    logic [STEPS-1:0] quo_reg  [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_stage
            logic [DW-1:0]    rem_p;
            logic [DW-1:0]    den_p;
            logic [STEPS-1:0] bits_p;
            logic [STEPS-1:0] quo_p;
            logic [DW:0]      trial;
            logic [DW:0]      diff;
            logic             ge;

            if (i == 0) begin : g_first
                assign rem_p  = rem_in;
                assign den_p  = den;
                assign bits_p = bits_in;
                assign quo_p  = '0;
            end else begin : g_next
                assign rem_p  = rem_reg[i-1];
                assign den_p  = den_reg[i-1];
                assign bits_p = bits_reg[i-1];
                assign quo_p  = quo_reg[i-1];
            end

            assign trial = {rem_p, bits_p[STEPS-1-i]};
            assign ge    = trial >= {1'b0, den_p};
            assign diff  = trial - {1'b0, den_p};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    den_reg[i]  <= den_p;
                    bits_reg[i] <= bits_p;
                    quo_reg[i]  <= {quo_p[STEPS-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = quo_reg[STEPS-1];

endmodule

// ===== hdl/rti_front.sv =====
module rti_front #(
    parameter int W = 21
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   org [3],
    input  logic signed [W-1:0]   dir [3],
    input  logic [rti_pkg::CFG_DATA_W-1:0] vertex0,
    input  logic [rti_pkg::CFG_DATA_W-1:0] edge1,
    input  logic [rti_pkg::CFG_DATA_W-1:0] edge2,
    input  logic [rti_pkg::THRESH_W-1:0]   det_thresh,
    output rti_pkg::front_t       fo
);

    localparam int TW = W + 1;
    localparam int CW = (2*W + 1 < 64) ? 2*W + 1 : 64;
    localparam int QW = (2*W + 2 < 64) ? 2*W + 2 : 64;
    localparam int EW = (3*W > 63) ? 3*W : 63;
    localparam int SW = rti_pkg::DOT_W;

    function automatic logic signed [SW-1:0] sum3(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic signed [63:0] c);
        return SW'(a) + SW'(b) + SW'(c);
    endfunction

    logic [EW-1:0] v0_ext, e1_ext, e2_ext;
    logic signed [W-1:0] v0 [3];
    logic signed [W-1:0] e1 [3];
    logic signed [W-1:0] e2 [3];

    assign v0_ext = EW'(vertex0);
    assign e1_ext = EW'(edge1);
    assign e2_ext = EW'(edge2);

    logic [7:0]            vld_reg;
    logic signed [W-1:0]   dir_reg  [5][3];
    logic signed [TW-1:0]  tvec_reg [4][3];
    logic signed [CW-1:0]  pvec_reg [3];
    logic signed [QW-1:0]  qvec_reg [3];
    logic signed [63:0]    pa [3], pb [3], qa [3], qb [3];
    logic signed [63:0]    det_t [3], su_t [3], sv_t [3], st_t [3];
    logic signed [SW-1:0]  det_sum_reg, su_sum_reg;
    logic signed [SW-1:0]  sv_sum_reg, st_sum_reg, su_adj_reg;
    logic                  dneg_reg;
    logic [63:0]           dmag_reg;
    rti_pkg::front_t       fo_reg;

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_axis
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;

            assign v0[k] = $signed(v0_ext[k*W +: W]);
            assign e1[k] = $signed(e1_ext[k*W +: W]);
            assign e2[k] = $signed(e2_ext[k*W +: W]);

            // pvec = dir x edge2, from stage 0 to stage 2
            rti_mul #(.AW(W), .BW(W)) u_pa (
                .aclk(aclk), .en(en), .a(dir_reg[0][K1]), .b(e2[K2]), .p(pa[k]));
            rti_mul #(.AW(W), .BW(W)) u_pb (
                .aclk(aclk), .en(en), .a(dir_reg[0][K2]), .b(e2[K1]), .p(pb[k]));

            // qvec = tvec x edge1, from stage 1 to stage 3
            rti_mul #(.AW(TW), .BW(W)) u_qa (
                .aclk(aclk), .en(en), .a(tvec_reg[1][K1]), .b(e1[K2]), .p(qa[k]));
            rti_mul #(.AW(TW), .BW(W)) u_qb (
                .aclk(aclk), .en(en), .a(tvec_reg[1][K2]), .b(e1[K1]), .p(qb[k]));

            // det and u terms, from stage 3 to stage 5
            rti_mul #(.AW(W), .BW(CW)) u_det (
                .aclk(aclk), .en(en), .a(e1[k]), .b(pvec_reg[k]), .p(det_t[k]));
            rti_mul #(.AW(TW), .BW(CW)) u_su (
                .aclk(aclk), .en(en), .a(tvec_reg[3][k]), .b(pvec_reg[k]), .p(su_t[k]));

            // v and distance terms, from stage 4 to stage 6
            rti_mul #(.AW(W), .BW(QW)) u_sv (
                .aclk(aclk), .en(en), .a(dir_reg[4][k]), .b(qvec_reg[k]), .p(sv_t[k]));
            rti_mul #(.AW(W), .BW(QW)) u_st (
                .aclk(aclk), .en(en), .a(e2[k]), .b(qvec_reg[k]), .p(st_t[k]));

            always_ff @(posedge aclk) begin
                if (en) begin
                    dir_reg[0][k]  <= dir[k];
                    dir_reg[1][k]  <= dir_reg[0][k];
                    dir_reg[2][k]  <= dir_reg[1][k];
                    dir_reg[3][k]  <= dir_reg[2][k];
                    dir_reg[4][k]  <= dir_reg[3][k];
                    tvec_reg[0][k] <= TW'(org[k]) - TW'(v0[k]);
                    tvec_reg[1][k] <= tvec_reg[0][k];
                    tvec_reg[2][k] <= tvec_reg[1][k];
                    tvec_reg[3][k] <= tvec_reg[2][k];
                    pvec_reg[k]    <= CW'(pa[k] - pb[k]);
                    qvec_reg[k]    <= QW'(qa[k] - qb[k]);
                end
            end
        end
    endgenerate

    // Stage 7: magnitude of the determinant, its sign folded into u.
    logic signed [SW-1:0] det_abs;
    logic signed [SW-1:0] su_adj_next;
    logic                 dneg_next;

    assign dneg_next   = det_sum_reg[SW-1];
    assign det_abs     = dneg_next ? -det_sum_reg : det_sum_reg;
    assign su_adj_next = dneg_next ? -su_sum_reg : su_sum_reg;

    // Stage 8: classification.
    logic signed [SW-1:0] sv_adj, st_adj, st_abs;
    logic [63:0]          uv_sum;
    logic                 par, u_out, v_out;
    rti_pkg::front_t      fo_next;

    assign sv_adj = dneg_reg ? -sv_sum_reg : sv_sum_reg;
    assign st_adj = dneg_reg ? -st_sum_reg : st_sum_reg;
    assign st_abs = st_adj[SW-1] ? -st_adj : st_adj;
    assign uv_sum = su_adj_reg[63:0] + sv_adj[63:0];
    assign par    = (dmag_reg == 64'd0) || (dmag_reg < 64'(det_thresh));
    assign u_out  = (su_adj_reg[SW-1:64] != '0) || (su_adj_reg[63:0] > dmag_reg);
    assign v_out  = (sv_adj[SW-1:64] != '0) || (sv_adj[63:0] > dmag_reg) || (uv_sum > dmag_reg);

    always_comb begin
        fo_next.valid = vld_reg[7];
        fo_next.tneg  = st_adj[SW-1];
        fo_next.tmag  = st_abs[63:0];
        fo_next.dmag  = dmag_reg;
        fo_next.u_num = su_adj_reg[63:0];
        fo_next.v_num = sv_adj[63:0];
        priority if (par) begin
            fo_next.status = rti_pkg::ST_PARALLEL;
        end else if (u_out) begin
            fo_next.status = rti_pkg::ST_U_OUT;
        end else if (v_out) begin
            fo_next.status = rti_pkg::ST_V_OUT;
        end else begin
            fo_next.status = rti_pkg::ST_HIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_sum_reg <= sum3(det_t[0], det_t[1], det_t[2]);
            su_sum_reg  <= sum3(su_t[0], su_t[1], su_t[2]);
            sv_sum_reg  <= sum3(sv_t[0], sv_t[1], sv_t[2]);
            st_sum_reg  <= sum3(st_t[0], st_t[1], st_t[2]);
            dneg_reg    <= dneg_next;
            dmag_reg    <= det_abs[63:0];
            su_adj_reg  <= su_adj_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            fo_reg  <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], in_valid};
            fo_reg  <= fo_next;
        end
    end

    assign fo = fo_reg;

endmodule

// ===== hdl/rti_checker.sv =====
module rti_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rti_pkg::OUT_TDATA_W-1:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != rti_pkg::ST_HIT) |-> (m_tdata[67:2] == '0))
        else $error("missed ray carries nonzero distance or barycentrics");

    a_bary_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50:34] <= 17'd65536) && (m_tdata[67:51] <= 17'd65536))
        else $error("barycentric coordinate above one");

endmodule

bind ray_triangle_intersection rti_checker u_rti_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
